@@ hw/rtl/ffdo_pkg.sv @@
package ffdo_pkg;

  // default sizes handed to the top level
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_FRAME_BYTES = 256;

  // depth of the command queue between front and back, power of two
  localparam int CMD_Q_DEPTH = 4;

  // input opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_COUNTER = 2'd2;

  // result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_DISCARD = 3'd1;
  localparam logic [2:0] ST_COMMIT  = 3'd2;
  localparam logic [2:0] ST_EVICT   = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;
  localparam logic [2:0] ST_EMPTY   = 3'd6;
  localparam logic [2:0] ST_COUNTER = 3'd7;

  // buffer access carried by a command
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_WRITE = 2'd1;
  localparam logic [1:0] MEM_READ  = 2'd2;

endpackage

@@ hw/rtl/ffdo_if.sv @@
// request channel
interface ffdo_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output opcode, output data_byte, output end_of_frame,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input end_of_frame,
                output ready);
endinterface

// result channel
interface ffdo_rsp_if #(parameter int LEVEL_W = 4);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         out_byte;
  logic               out_last;
  logic [31:0]        frame_counter;
  logic [LEVEL_W-1:0] queue_level;

  modport source (output valid, output status, output out_byte, output out_last,
                  output frame_counter, output queue_level, input ready);
  modport sink (input valid, input status, input out_byte, input out_last,
                input frame_counter, input queue_level, output ready);
endinterface

@@ hw/rtl/ffdo_front.sv @@
module ffdo_front #(
  parameter int QUEUE_DEPTH = ffdo_pkg::DEF_QUEUE_DEPTH,
  parameter int FRAME_BYTES = ffdo_pkg::DEF_FRAME_BYTES,
  parameter type cmd_t = logic
) (
  input  logic      clk,
  input  logic      rst,
  ffdo_req_if.sink  item_in,
  input  logic      q_full,
  output logic      push,
  output cmd_t      push_cmd
);

  localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W      = $clog2(FRAME_BYTES + 1);
  localparam int OFF_W      = $clog2(FRAME_BYTES);
  localparam int ADDR_W     = $clog2(SLOT_COUNT * FRAME_BYTES);

  logic [SLOT_W-1:0]  head_slot, head_slot_next;
  logic [SLOT_W-1:0]  staging_slot, staging_slot_next;
  logic [LEVEL_W-1:0] frames_queued, frames_queued_next;
  logic [LEN_W-1:0]   staging_length, staging_length_next;
  logic               staging_overflow, staging_overflow_next;
  logic [OFF_W-1:0]   read_offset, read_offset_next;
  logic [31:0]        commit_counter, commit_counter_next;
  logic [LEN_W-1:0]   frame_lengths [SLOT_COUNT];

  logic               commit;
  logic               queue_full;
  logic               byte_drop;
  logic [LEN_W-1:0]   length_inc;
  logic [LEN_W-1:0]   head_length;
  logic [LEN_W-1:0]   offset_inc;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = ADDR_W'(s) * ADDR_W'(FRAME_BYTES);
  endfunction

  // one item per cycle while the command queue has room
  assign item_in.ready = !q_full;
  assign push          = item_in.valid && !q_full;

  assign queue_full  = (frames_queued == LEVEL_W'(QUEUE_DEPTH));
  assign byte_drop   = staging_overflow || (staging_length == LEN_W'(FRAME_BYTES));
  assign length_inc  = staging_length + 1'b1;
  assign head_length = frame_lengths[head_slot];
  assign offset_inc  = LEN_W'(read_offset) + 1'b1;

  // classify the item and work out the bookkeeping
  always_comb begin
    head_slot_next        = head_slot;
    staging_slot_next     = staging_slot;
    frames_queued_next    = frames_queued;
    staging_length_next   = staging_length;
    staging_overflow_next = staging_overflow;
    read_offset_next      = read_offset;
    commit_counter_next   = commit_counter;
    commit                = 1'b0;
    push_cmd.kind         = ffdo_pkg::MEM_NONE;
    push_cmd.addr         = '0;
    push_cmd.wdata        = item_in.data_byte;
    push_cmd.status       = ffdo_pkg::ST_COUNTER;
    push_cmd.last         = 1'b0;
    unique case (item_in.opcode)
      ffdo_pkg::OP_WRITE: begin
        if (byte_drop) begin
          staging_overflow_next = 1'b1;
        end else begin
          push_cmd.kind       = ffdo_pkg::MEM_WRITE;
          push_cmd.addr       = slot_base(staging_slot) + ADDR_W'(staging_length);
          staging_length_next = length_inc;
        end
        if (!item_in.end_of_frame) begin
          push_cmd.status = byte_drop ? ffdo_pkg::ST_DISCARD : ffdo_pkg::ST_STORED;
        end else if (byte_drop) begin
          // oversize frame thrown away whole
          push_cmd.status       = ffdo_pkg::ST_REJECT;
          staging_length_next   = '0;
          staging_overflow_next = 1'b0;
        end else begin
          commit              = 1'b1;
          push_cmd.status     = ffdo_pkg::ST_COMMIT;
          staging_slot_next   = next_slot(staging_slot);
          staging_length_next = '0;
          commit_counter_next = commit_counter + 1'b1;
          if (queue_full) begin
            // drop the oldest frame, level stays at the top
            push_cmd.status  = ffdo_pkg::ST_EVICT;
            head_slot_next   = next_slot(head_slot);
            read_offset_next = '0;
          end else begin
            frames_queued_next = frames_queued + 1'b1;
          end
        end
      end
      ffdo_pkg::OP_READ: begin
        if (frames_queued == '0) begin
          push_cmd.status = ffdo_pkg::ST_EMPTY;
        end else begin
          push_cmd.status = ffdo_pkg::ST_READ;
          push_cmd.kind   = ffdo_pkg::MEM_READ;
          push_cmd.addr   = slot_base(head_slot) + ADDR_W'(read_offset);
          if (offset_inc >= head_length) begin
            push_cmd.last      = 1'b1;
            head_slot_next     = next_slot(head_slot);
            frames_queued_next = frames_queued - 1'b1;
            read_offset_next   = '0;
          end else begin
            read_offset_next = OFF_W'(offset_inc);
          end
        end
      end
      default: begin
        push_cmd.status = ffdo_pkg::ST_COUNTER;
      end
    endcase
    push_cmd.counter = commit_counter_next;
    push_cmd.level   = frames_queued_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot        <= '0;
      staging_slot     <= '0;
      frames_queued    <= '0;
      staging_length   <= '0;
      staging_overflow <= 1'b0;
      read_offset      <= '0;
      commit_counter   <= '0;
    end else if (push) begin
      head_slot        <= head_slot_next;
      staging_slot     <= staging_slot_next;
      frames_queued    <= frames_queued_next;
      staging_length   <= staging_length_next;
      staging_overflow <= staging_overflow_next;
      read_offset      <= read_offset_next;
      commit_counter   <= commit_counter_next;
    end
  end

  // frame length table, written at commit
  always_ff @(posedge clk) begin
    if (push && commit) begin
      frame_lengths[staging_slot] <= length_inc;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    frames_queued <= LEVEL_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_staging_bound: assert property (@(posedge clk) disable iff (rst)
    staging_length <= LEN_W'(FRAME_BYTES))
    else $error("staging length above frame size");

  a_commit_count: assert property (@(posedge clk) disable iff (rst)
    (push && commit) |=> (commit_counter == $past(commit_counter) + 32'd1))
    else $error("commit did not advance frame counter");

  a_evict_level: assert property (@(posedge clk) disable iff (rst)
    (push && commit && queue_full) |=> (frames_queued == LEVEL_W'(QUEUE_DEPTH)))
    else $error("eviction changed queue level");

endmodule

@@ hw/rtl/ffdo_cmd_q.sv @@
module ffdo_cmd_q #(
  parameter type cmd_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int PTR_W = $clog2(ffdo_pkg::CMD_Q_DEPTH);

  cmd_t             entries [ffdo_pkg::CMD_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(ffdo_pkg::CMD_Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/ffdo_back.sv @@
module ffdo_back #(
  parameter int QUEUE_DEPTH = ffdo_pkg::DEF_QUEUE_DEPTH,
  parameter int FRAME_BYTES = ffdo_pkg::DEF_FRAME_BYTES,
  parameter type cmd_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        q_cmd,
  input  logic        q_empty,
  output logic        q_pop,
  ffdo_rsp_if.source  result_out
);

  localparam int STORE_DEPTH = (QUEUE_DEPTH + 1) * FRAME_BYTES;

  logic [7:0] frame_store [STORE_DEPTH];
  logic [7:0] rd_data;
  logic       res_valid;
  cmd_t       res_cmd;
  logic       advance;

  // the result register moves when empty or taken
  assign advance = !res_valid || result_out.ready;
  assign q_pop   = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_cmd <= q_cmd;
    end
  end

  // frame buffer, at most one access per command
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == ffdo_pkg::MEM_WRITE)) begin
      frame_store[q_cmd.addr] <= q_cmd.wdata;
    end
    if (q_pop && (q_cmd.kind == ffdo_pkg::MEM_READ)) begin
      rd_data <= frame_store[q_cmd.addr];
    end
  end

  // result fields
  assign result_out.valid         = res_valid;
  assign result_out.status        = res_cmd.status;
  assign result_out.out_byte      = (res_cmd.kind == ffdo_pkg::MEM_READ) ? rd_data : 8'd0;
  assign result_out.out_last      = res_cmd.last;
  assign result_out.frame_counter = res_cmd.counter;
  assign result_out.queue_level   = res_cmd.level;

endmodule

@@ hw/rtl/frame_fifo_drop_oldest.sv @@
// Byte-serial frame queue that drops its oldest frame when full.
// item_in carries one request per item: opcode write byte (data_byte, with
// end_of_frame on the last byte), read next queued byte, or read frame counter.
// result_out returns exactly one result per request, in order, with status,
// out_byte and out_last for reads, the committed-frame counter and the number
// of frames queued after that request.
// A front stage classifies each request and updates the queue bookkeeping in
// the cycle it is accepted; a four-entry command queue feeds a back stage that
// does the frame buffer access, if any, and holds the result register.
// Throughput is one item per cycle while the command queue has room, bounded
// by the one buffer port in the back stage; each result passes through the
// command queue and then the result register before it becomes valid.
// When result_out stalls, results collect in the command queue and item_in
// keeps accepting until that queue fills, then ready drops.
// Synchronous reset empties the queue, clears the staging frame and zeroes
// the counter; the frame buffer is not cleared and needs no pass after reset.
module frame_fifo_drop_oldest #(
  parameter int QUEUE_DEPTH = ffdo_pkg::DEF_QUEUE_DEPTH,
  parameter int FRAME_BYTES = ffdo_pkg::DEF_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  ffdo_req_if.sink   item_in,
  ffdo_rsp_if.source result_out
);

  localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
  localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W     = $clog2(SLOT_COUNT * FRAME_BYTES);

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         wdata;
    logic [2:0]         status;
    logic               last;
    logic [31:0]        counter;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  ffdo_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES),
    .cmd_t       (cmd_t)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ffdo_cmd_q #(
    .cmd_t (cmd_t)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ffdo_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_cmd      (pop_cmd),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .result_out (result_out)
  );

endmodule

@@ dv/frame_fifo_drop_oldest_test.sv @@
module frame_fifo_drop_oldest_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = ffdo_pkg::DEF_QUEUE_DEPTH;
  localparam int FBYTES = ffdo_pkg::DEF_FRAME_BYTES;
  localparam int SLOTS = QDEPTH + 1;
  localparam int LEVEL_W = 4;
  // spare opcode, decoded as a counter read
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         data;
    logic               last;
    logic [31:0]        count;
    logic [LEVEL_W-1:0] level;
  } frame_result_t;

  // tracks the frame queue and checks each result against it
  class frame_queue_tracker;
    logic [7:0]    buffer [SLOTS*FBYTES];
    int unsigned   lengths [SLOTS];
    int unsigned   head, stage, queued, stage_len, rd_off;
    bit            overflow;
    logic [31:0]   commits;
    frame_result_t awaited_results [$];
    int unsigned   errors;
    int unsigned   status_seen [8];

    function new();
      head = 0;
      stage = 0;
      queued = 0;
      stage_len = 0;
      rd_off = 0;
      overflow = 0;
      commits = '0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned wrap_slot(int unsigned s);
      return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // work out the result of one accepted item
    function void note_request(logic [1:0] op, logic [7:0] d, logic eof);
      frame_result_t r;
      int unsigned off;
      r = '0;
      case (op)
        ffdo_pkg::OP_WRITE: begin
          if (overflow || stage_len >= FBYTES) begin
            overflow = 1;
          end else begin
            buffer[stage*FBYTES + stage_len] = d;
            stage_len++;
          end
          if (!eof) begin
            r.status = overflow ? ffdo_pkg::ST_DISCARD : ffdo_pkg::ST_STORED;
          end else if (overflow) begin
            // oversize frame dropped whole, counter untouched
            r.status = ffdo_pkg::ST_REJECT;
            stage_len = 0;
            overflow = 0;
          end else begin
            r.status = ffdo_pkg::ST_COMMIT;
            // full queue: oldest frame goes, reading restarts on new head
            if (queued >= QDEPTH) begin
              head = wrap_slot(head);
              queued--;
              rd_off = 0;
              r.status = ffdo_pkg::ST_EVICT;
            end
            lengths[stage] = stage_len;
            stage = wrap_slot(stage);
            queued++;
            stage_len = 0;
            commits++;
          end
        end
        ffdo_pkg::OP_READ: begin
          if (queued == 0) begin
            r.status = ffdo_pkg::ST_EMPTY;
          end else begin
            off = (rd_off >= FBYTES) ? FBYTES - 1 : rd_off;
            r.status = ffdo_pkg::ST_READ;
            r.data = buffer[head*FBYTES + off];
            if (off + 1 >= lengths[head]) begin
              r.last = 1'b1;
              head = wrap_slot(head);
              queued--;
              rd_off = 0;
            end else begin
              rd_off = off + 1;
            end
          end
        end
        default: r.status = ffdo_pkg::ST_COUNTER;
      endcase
      r.count = commits;
      r.level = LEVEL_W'(queued);
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // compare one result with the oldest expectation
    function void check_response(frame_result_t got);
      frame_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got status %0d level %0d",
                   $time, got.status, got.level);
        return;
      end
      want = awaited_results.pop_front();
      status_seen[want.status]++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_byte", 32'(want.data), 32'(got.data));
      compare_field("out_last", 32'(want.last), 32'(got.last));
      compare_field("frame_counter", want.count, got.count);
      compare_field("queue_level", 32'(want.level), 32'(got.level));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffdo_req_if item_ch ();
  ffdo_rsp_if #(.LEVEL_W(LEVEL_W)) result_ch ();

  frame_fifo_drop_oldest #(
    .QUEUE_DEPTH(QDEPTH),
    .FRAME_BYTES(FBYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_in(item_ch),
    .result_out(result_ch)
  );

  frame_queue_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    result_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // check every accepted result
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_response({result_ch.status, result_ch.out_byte, result_ch.out_last,
                              result_ch.frame_counter, result_ch.queue_level});
  end

  // hand over one item, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [7:0] d, input logic eof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.data_byte <= d;
    item_ch.end_of_frame <= eof;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_request(op, d, eof);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0:       op = ffdo_pkg::OP_READ;
      1:       op = ffdo_pkg::OP_COUNTER;
      default: op = OP_SPARE;
    endcase
    send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic read_burst(input int unsigned n);
    repeat (n)
      send_item(ffdo_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // one frame of random bytes, other items mixed in now and then
  task automatic write_frame(input int unsigned len, input int unsigned mix_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < mix_pct)
        send_noise();
      send_item(ffdo_pkg::OP_WRITE, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // sender stays quiet until every outstanding result is back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // random frames and reads, swinging between filling and draining the queue
  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned read_share;
    int unsigned pick;
    stop_at = items_sent + budget;
    read_share = 35;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0)
        read_share = $urandom_range(0, 2) * 25 + 10;
      pick = $urandom_range(0, 99);
      if (pick < read_share)
        read_burst($urandom_range(1, 16));
      else if (pick < read_share + 10)
        send_noise();
      else
        write_frame($urandom_range(1, 12), 10);
    end
  endtask

  // run ends here if the block hangs
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.opcode = ffdo_pkg::OP_WRITE;
    item_ch.data_byte = '0;
    item_ch.end_of_frame = 1'b0;
    result_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue, counter reads, short frames, full-queue eviction
    send_item(ffdo_pkg::OP_READ, 8'hFF, 1'b1);
    send_item(ffdo_pkg::OP_COUNTER, 8'h00, 1'b0);
    send_item(OP_SPARE, 8'hFF, 1'b1);
    send_item(ffdo_pkg::OP_WRITE, 8'h00, 1'b1);
    send_item(ffdo_pkg::OP_WRITE, 8'hFF, 1'b0);
    send_item(ffdo_pkg::OP_WRITE, 8'hA5, 1'b1);
    read_burst(4);
    send_item(ffdo_pkg::OP_READ, 8'h00, 1'b0);
    for (int i = 0; i < QDEPTH + 1; i++)
      send_item(ffdo_pkg::OP_WRITE, 8'(i * 31), 1'b1);
    send_item(ffdo_pkg::OP_READ, 8'h5A, 1'b0);
    send_item(ffdo_pkg::OP_COUNTER, 8'hFF, 1'b1);
    drain_results();

    // sender rarely idle, receiver mostly stalled
    send_idle_pct = 10;
    recv_idle_pct = 80;
    run_phase(150);
    drain_results();

    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 80;
    recv_idle_pct = 10;
    run_phase(150);
    drain_results();

    // no idling: full-size frame read back whole, then an oversize frame
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (tracker.queued != 0)
      send_item(ffdo_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    write_frame(FBYTES, 0);
    read_burst(FBYTES);
    write_frame(FBYTES + 2, 0);
    send_item(ffdo_pkg::OP_READ, 8'h00, 1'b1);
    run_phase(40);

    drain_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d items: %0d commits, %0d evictions, %0d oversize rejects",
             items_sent, tracker.status_seen[ffdo_pkg::ST_COMMIT],
             tracker.status_seen[ffdo_pkg::ST_EVICT],
             tracker.status_seen[ffdo_pkg::ST_REJECT]);
    $display("  %0d bytes read, %0d empty reads, %0d counter reads, %0d mismatches",
             tracker.status_seen[ffdo_pkg::ST_READ], tracker.status_seen[ffdo_pkg::ST_EMPTY],
             tracker.status_seen[ffdo_pkg::ST_COUNTER], tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ffdo_pkg.sv
hw/rtl/ffdo_if.sv
hw/rtl/ffdo_front.sv
hw/rtl/ffdo_cmd_q.sv
hw/rtl/ffdo_back.sv
hw/rtl/frame_fifo_drop_oldest.sv
dv/frame_fifo_drop_oldest_test.sv
